>>> hw/rtl/odo_pkg.sv
// Shared types, constants and tables for the three-wheel odometry block.
package odo_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN = 24;

   localparam int COUNT_W = 32;
   localparam int GAIN_W = 32;
   localparam int POS_W = 48;
   localparam int HEAD_W = 25;
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 33;
   localparam int MUL_HALF = 24;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ANGLE_W = 34;
   localparam int TRIG_W = 33;

   localparam logic [HEAD_W-1:0] DEG360_Q16 = 25'd23592960;
   localparam logic signed [ANGLE_W-1:0] DEG90_Q24 = 34'sd1509949440;
   localparam logic signed [ANGLE_W-1:0] DEG180_Q24 = 34'sd3019898880;
   localparam logic signed [ANGLE_W-1:0] DEG270_Q24 = 34'sd4529848320;
   localparam logic signed [ANGLE_W-1:0] DEG360_Q24 = 34'sd6039797760;
   localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 33'sd652032874;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_HEADING_GAIN = 2'd0,
      REG_FORWARD_GAIN = 2'd1,
      REG_STRAFE_GAIN  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      SH_8  = 2'd0,
      SH_9  = 2'd1,
      SH_30 = 2'd2
   } shift_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      shift_type          shift;
      logic               heading_lim;
   } mul_cmd_type;

   function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0: v = 32'sd754974720;
         5'd1: v = 32'sd445687602;
         5'd2: v = 32'sd235489088;
         5'd3: v = 32'sd119537938;
         5'd4: v = 32'sd60000934;
         5'd5: v = 32'sd30029717;
         5'd6: v = 32'sd15018523;
         5'd7: v = 32'sd7509720;
         5'd8: v = 32'sd3754917;
         5'd9: v = 32'sd1877466;
         5'd10: v = 32'sd938734;
         5'd11: v = 32'sd469367;
         5'd12: v = 32'sd234684;
         5'd13: v = 32'sd117342;
         5'd14: v = 32'sd58671;
         5'd15: v = 32'sd29335;
         5'd16: v = 32'sd14668;
         5'd17: v = 32'sd7334;
         5'd18: v = 32'sd3667;
         5'd19: v = 32'sd1833;
         5'd20: v = 32'sd917;
         5'd21: v = 32'sd458;
         5'd22: v = 32'sd229;
         5'd23: v = 32'sd115;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp48(input logic signed [POS_W:0] v);
      logic signed [POS_W-1:0] r;
      if (v > $signed({POS_MAX[POS_W-1], POS_MAX})) begin
         r = POS_MAX;
      end else if (v < $signed({POS_MIN[POS_W-1], POS_MIN})) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/three_wheel_odometry.sv
// Top level of the three-wheel odometry block: sequencer, state and channels.
//
// Each request transfer carries three absolute encoder counts (right, left,
// back). The block forms the deltas against the previous sample, updates the
// heading and the X/Y position, and returns one response transfer holding the
// new position and heading. Gains are written through the csr_ channel, which
// is always ready; writes are expected only while the block is idle.
// Each item passes through an accept step, seven products through the single
// shared multiplier (each a start step and then a wait for it to finish), a
// sum step and an accumulate step. The CORDIC is started with the forward
// product and runs while the forward and strafe products are formed; the trig
// products wait until it is no longer busy.
// req_ready is high only while the sequencer is idle; a finished result sits
// in an output register, so the next request is taken while it waits.
// If the receiver stalls, the following item completes its work and holds
// in its final step until the pending response is transferred.
// Reset clears gains, previous counts, heading and position to zero.
module three_wheel_odometry #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [odo_pkg::COUNT_W-1:0]    req_right_count,
   input  logic signed [odo_pkg::COUNT_W-1:0]    req_left_count,
   input  logic signed [odo_pkg::COUNT_W-1:0]    req_back_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [odo_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [odo_pkg::POS_W-1:0]      rsp_pos_y,
   output logic [odo_pkg::HEAD_W-1:0]            rsp_heading,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [odo_pkg::GAIN_W-1:0]            csr_data
);
   import odo_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_MSTART, ST_MWAIT, ST_SUM, ST_ACC} state_type;
   typedef enum logic [2:0] {
      OP_DH, OP_FWD, OP_STR, OP_FWD_SIN, OP_STR_COS, OP_STR_SIN, OP_FWD_COS
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [GAIN_W-1:0] hgain_ff, hgain_in, fgain_ff, fgain_in, sgain_ff, sgain_in;
   logic [COUNT_W-1:0] prev_r_ff, prev_r_in, prev_l_ff, prev_l_in, prev_b_ff, prev_b_in;
   logic [HEAD_W-1:0] heading_ff, heading_in;
   logic signed [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COUNT_W:0] sum_ff, sum_in, dfw_ff, dfw_in;
   logic signed [COUNT_W+2:0] dst_ff, dst_in;
   logic signed [POS_W-1:0] fwd_ff, fwd_in, str_ff, str_in;
   logic signed [POS_W-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [POS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [HEAD_W-1:0] rh_ff, rh_in;

   logic signed [COUNT_W-1:0] dr, dl, db;
   logic signed [COUNT_W:0] dsum;
   logic signed [HEAD_W+1:0] h_new;
   mul_cmd_type cmd;
   logic mul_start, mul_done;
   logic signed [POS_W-1:0] mul_res;
   logic cordic_start, cordic_busy;
   logic signed [TRIG_W-1:0] sin_v, cos_v;

   odo_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .cmd(cmd),
      .done(mul_done), .result(mul_res)
   );

   odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .angle(heading_ff),
      .busy(cordic_busy), .sin_out(sin_v), .cos_out(cos_v)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      hgain_in = hgain_ff;
      fgain_in = fgain_ff;
      sgain_in = sgain_ff;
      prev_r_in = prev_r_ff;
      prev_l_in = prev_l_ff;
      prev_b_in = prev_b_ff;
      heading_in = heading_ff;
      x_in = x_ff;
      y_in = y_ff;
      sum_in = sum_ff;
      dfw_in = dfw_ff;
      dst_in = dst_ff;
      fwd_in = fwd_ff;
      str_in = str_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      rsp_valid_in = rsp_valid_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rh_in = rh_ff;
      mul_start = 1'b0;
      cordic_start = 1'b0;

      dr = req_right_count - $signed(prev_r_ff);
      dl = req_left_count - $signed(prev_l_ff);
      db = req_back_count - $signed(prev_b_ff);
      dsum = (COUNT_W+1)'(dr) + (COUNT_W+1)'(dl);

      h_new = $signed({2'b00, heading_ff}) + $signed(mul_res[HEAD_W+1:0]);

      case (op_ff)
         OP_DH: cmd = '{a: MUL_A_W'(sum_ff), b: MUL_B_W'($signed(hgain_ff)),
                        shift: SH_8, heading_lim: 1'b1};
         OP_FWD: cmd = '{a: MUL_A_W'(dfw_ff), b: MUL_B_W'($signed(fgain_ff)),
                         shift: SH_9, heading_lim: 1'b0};
         OP_STR: cmd = '{a: MUL_A_W'(dst_ff), b: MUL_B_W'($signed(sgain_ff)),
                         shift: SH_9, heading_lim: 1'b0};
         OP_FWD_SIN: cmd = '{a: fwd_ff, b: sin_v, shift: SH_30, heading_lim: 1'b0};
         OP_STR_COS: cmd = '{a: str_ff, b: cos_v, shift: SH_30, heading_lim: 1'b0};
         OP_STR_SIN: cmd = '{a: str_ff, b: sin_v, shift: SH_30, heading_lim: 1'b0};
         OP_FWD_COS: cmd = '{a: fwd_ff, b: cos_v, shift: SH_30, heading_lim: 1'b0};
         default: cmd = '{a: '0, b: '0, shift: SH_8, heading_lim: 1'b0};
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            REG_HEADING_GAIN: hgain_in = csr_data;
            REG_FORWARD_GAIN: fgain_in = csr_data;
            REG_STRAFE_GAIN: sgain_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sum_in = dsum;
               dfw_in = (COUNT_W+1)'(dl) - (COUNT_W+1)'(dr);
               dst_in = ((COUNT_W+3)'(db) <<< 1) - (COUNT_W+3)'(dsum);
               prev_r_in = req_right_count;
               prev_l_in = req_left_count;
               prev_b_in = req_back_count;
               op_in = OP_DH;
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            if (op_ff < OP_FWD_SIN || !cordic_busy) begin
               mul_start = 1'b1;
               cordic_start = (op_ff == OP_FWD);
               state_in = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (mul_done) begin
               state_in = ST_MSTART;
               case (op_ff)
                  OP_DH: begin
                     if (h_new > $signed({2'b00, DEG360_Q16})) begin
                        heading_in = HEAD_W'(h_new - $signed({2'b00, DEG360_Q16}));
                     end else if (h_new < 0) begin
                        heading_in = HEAD_W'(h_new + $signed({2'b00, DEG360_Q16}));
                     end else begin
                        heading_in = HEAD_W'(h_new);
                     end
                     op_in = OP_FWD;
                  end
                  OP_FWD: begin
                     fwd_in = mul_res;
                     op_in = OP_STR;
                  end
                  OP_STR: begin
                     str_in = mul_res;
                     op_in = OP_FWD_SIN;
                  end
                  OP_FWD_SIN: begin
                     t0_in = mul_res;
                     op_in = OP_STR_COS;
                  end
                  OP_STR_COS: begin
                     t1_in = mul_res;
                     op_in = OP_STR_SIN;
                  end
                  OP_STR_SIN: begin
                     t2_in = mul_res;
                     op_in = OP_FWD_COS;
                  end
                  OP_FWD_COS: begin
                     t3_in = mul_res;
                     state_in = ST_SUM;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SUM: begin
            dx_in = clamp48((POS_W+1)'(t0_ff) + (POS_W+1)'(t1_ff));
            dy_in = clamp48((POS_W+1)'(t2_ff) - (POS_W+1)'(t3_ff));
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               x_in = clamp48((POS_W+1)'(x_ff) + (POS_W+1)'(dx_ff));
               y_in = clamp48((POS_W+1)'(y_ff) + (POS_W+1)'(dy_ff));
               rx_in = x_in;
               ry_in = y_in;
               rh_in = heading_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_DH;
         hgain_ff <= '0;
         fgain_ff <= '0;
         sgain_ff <= '0;
         prev_r_ff <= '0;
         prev_l_ff <= '0;
         prev_b_ff <= '0;
         heading_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         hgain_ff <= hgain_in;
         fgain_ff <= fgain_in;
         sgain_ff <= sgain_in;
         prev_r_ff <= prev_r_in;
         prev_l_ff <= prev_l_in;
         prev_b_ff <= prev_b_in;
         heading_ff <= heading_in;
         x_ff <= x_in;
         y_ff <= y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff <= sum_in;
      dfw_ff <= dfw_in;
      dst_ff <= dst_in;
      fwd_ff <= fwd_in;
      str_ff <= str_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rh_ff <= rh_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rx_ff;
   assign rsp_pos_y = ry_ff;
   assign rsp_heading = rh_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff <= DEG360_Q16)
      else $error("Heading left the 0 to 360 degree range.");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MWAIT)
      else $error("Multiplier finished while the sequencer was not waiting.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request channel stayed ready after a transfer.");

   a_trig_settled: assert property (@(posedge clock) disable iff (reset)
      mul_start && op_ff >= OP_FWD_SIN |-> !cordic_busy)
      else $error("Trig product started before the CORDIC finished.");

endmodule

>>> hw/rtl/odo_mul.sv
// Shared multi-cycle signed multiply, shift and saturate unit.
module odo_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  odo_pkg::mul_cmd_type         cmd,
   output logic                         done,
   output logic signed [odo_pkg::POS_W-1:0] result
);
   import odo_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_type;

   mstate_type          state_ff, state_in;
   logic [MUL_A_W-1:0]  a_mag_ff, a_mag_in;
   logic [MUL_B_W-1:0]  b_mag_ff, b_mag_in;
   logic                neg_ff, neg_in;
   shift_type           shift_ff, shift_in;
   logic                hlim_ff, hlim_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                done_ff, done_in;
   logic signed [POS_W-1:0] res_ff, res_in;
   logic [PROD_W-1:0]   rsh;
   logic [POS_W-1:0]    lim;
   logic [POS_W-1:0]    mag;

   always_comb begin
      state_in = state_ff;
      a_mag_in = a_mag_ff;
      b_mag_in = b_mag_ff;
      neg_in = neg_ff;
      shift_in = shift_ff;
      hlim_in = hlim_ff;
      prod_in = prod_ff;
      done_in = 1'b0;
      res_in = res_ff;
      case (shift_ff)
         SH_8: rsh = prod_ff >> 8;
         SH_9: rsh = prod_ff >> 9;
         SH_30: rsh = prod_ff >> 30;
         default: rsh = prod_ff;
      endcase
      lim = hlim_ff ? {{(POS_W-HEAD_W){1'b0}}, DEG360_Q16} : POS_MAX;
      mag = (rsh > {{(PROD_W-POS_W){1'b0}}, lim}) ? lim : rsh[POS_W-1:0];
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               a_mag_in = cmd.a[MUL_A_W-1] ? (~cmd.a + 1'b1) : cmd.a;
               b_mag_in = cmd.b[MUL_B_W-1] ? (~cmd.b + 1'b1) : cmd.b;
               neg_in = cmd.a[MUL_A_W-1] ^ cmd.b[MUL_B_W-1];
               shift_in = cmd.shift;
               hlim_in = cmd.heading_lim;
               state_in = M_LO;
            end
         end
         M_LO: begin
            prod_in = PROD_W'(a_mag_ff[MUL_HALF-1:0] * b_mag_ff);
            state_in = M_HI;
         end
         M_HI: begin
            prod_in = prod_ff + (PROD_W'(a_mag_ff[MUL_A_W-1:MUL_HALF] * b_mag_ff) << MUL_HALF);
            state_in = M_FIN;
         end
         M_FIN: begin
            res_in = neg_ff ? -$signed(mag) : $signed(mag);
            done_in = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      neg_ff <= neg_in;
      shift_ff <= shift_in;
      hlim_ff <= hlim_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

>>> hw/rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a heading.
module odo_cordic #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [odo_pkg::HEAD_W-1:0]         angle,
   output logic                               busy,
   output logic signed [odo_pkg::TRIG_W-1:0]  sin_out,
   output logic signed [odo_pkg::TRIG_W-1:0]  cos_out
);
   import odo_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);

   typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_type;

   cstate_type               state_ff, state_in;
   logic [IW-1:0]            i_ff, i_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in, z0;
   logic                     flip_ff, flip_in;
   logic signed [TRIG_W-1:0] xs, ys;
   logic signed [ANGLE_W-1:0] at;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      z0 = $signed({1'b0, angle, 8'b0});
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = ANGLE_W'(atan_deg(5'(i_ff)));
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               if (z0 > DEG270_Q24) begin
                  z_in = z0 - DEG360_Q24;
                  flip_in = 1'b0;
               end else if (z0 > DEG90_Q24) begin
                  z_in = z0 - DEG180_Q24;
                  flip_in = 1'b1;
               end else begin
                  z_in = z0;
                  flip_in = 1'b0;
               end
               x_in = CORDIC_K_Q30;
               y_in = '0;
               i_in = '0;
               state_in = C_RUN;
            end
         end
         C_RUN: begin
            if (!z_ff[ANGLE_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = C_FIN;
            end
         end
         C_FIN: begin
            if (flip_ff) begin
               x_in = -x_ff;
               y_in = -y_ff;
            end
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

   assign busy = (state_ff != C_IDLE);
   assign sin_out = y_ff;
   assign cos_out = x_ff;

endmodule
